>>> rtl/taa_pkg.sv
// shared types and constants for the threshold alarm aggregator
package taa_pkg;

	localparam int CHANNELS = 8;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(CHANNELS + 1);

	typedef enum logic [1:0] {
		LVL_NORMAL = 2'd0,
		LVL_LOW    = 2'd1,
		LVL_HIGH   = 2'd2
	} level_t;

	// one alarm channel as held in the table
	typedef struct packed {
		logic [3:0]         ctype;
		logic               dir;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} chan_t;

	// write request from the sequencer to the channel table
	typedef struct packed {
		logic             add_en;
		logic [IDX_W-1:0] add_idx;
		chan_t            add_chan;
		logic             lvl_en;
		logic [IDX_W-1:0] lvl_idx;
		level_t           lvl_val;
	} tbl_wr_t;

endpackage

>>> rtl/taa_table.sv
// channel table storage with one write path and one registered read port
module taa_table (
	input  logic                        clk,
	input  taa_pkg::tbl_wr_t            wr,
	input  logic [taa_pkg::IDX_W-1:0]   rd_addr,
	output taa_pkg::chan_t              rd_chan,
	output taa_pkg::level_t             rd_level
);

	taa_pkg::chan_t  chan_mem [taa_pkg::CHANNELS];
	taa_pkg::level_t lvl_mem  [taa_pkg::CHANNELS];

	always_ff @(posedge clk) begin
		if (wr.add_en) begin
			chan_mem[wr.add_idx] <= wr.add_chan;
			lvl_mem[wr.add_idx]  <= taa_pkg::LVL_NORMAL;
		end else if (wr.lvl_en) begin
			lvl_mem[wr.lvl_idx] <= wr.lvl_val;
		end
		rd_chan  <= chan_mem[rd_addr];
		rd_level <= lvl_mem[rd_addr];
	end

endmodule

>>> rtl/taa_classify.sv
// shared limit compare unit: grades one sample against one channel's limits
module taa_classify (
	input  logic               dir,
	input  logic signed [31:0] lo,
	input  logic signed [31:0] hi,
	input  logic signed [31:0] sample,
	output taa_pkg::level_t    level
);

	logic below_lo;
	logic above_hi;

	assign below_lo = sample < lo;
	assign above_hi = sample > hi;

	always_comb begin
		if (!dir) begin
			// alarm above limits
			if (below_lo)      level = taa_pkg::LVL_NORMAL;
			else if (above_hi) level = taa_pkg::LVL_HIGH;
			else               level = taa_pkg::LVL_LOW;
		end else begin
			// alarm below limits
			if (above_hi)      level = taa_pkg::LVL_NORMAL;
			else if (below_lo) level = taa_pkg::LVL_HIGH;
			else               level = taa_pkg::LVL_LOW;
		end
	end

endmodule

>>> rtl/threshold_alarm_aggregator_core.sv
// top level: sequencer, config registers and result register of the alarm aggregator
// usage
// - input channel (in_valid / in_stall): one beat is either a register item
//   (op = 0, appends a channel to the table if it has room) or a check item (op = 1, grades
//   every channel of channel_type against sample and re-evaluates the overall level)
// - output channel (out_valid / out_stall): exactly one result beat per input beat,
//   in order; the result sits in an output register until taken
// - config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0, 1, 2
//   write the normal, low and high reload values; cfg_ready is always high,
//   other indexes are dropped; write only while the block is idle
// timing
// - register item: the accepting edge moves the sequencer to FIN, which loads the result once the output is free
// - check item: the sequencer walks every table entry in WALK, then loads the result in FIN;
//   one table entry per cycle
//   through the single limit compare unit, the next entry is fetched meanwhile
// - in_stall is high from the accepting edge until the result is loaded into the
//   output register; a new beat can be taken while that result still waits
// reset
// - arst_n clears channel count, overall level, sequencer and output valid;
//   reload values go to 1000 / 500 / 100; a stalled receiver parks the sequencer
module threshold_alarm_aggregator_core (
	input  logic               clk,
	input  logic               arst_n,
	// input beats
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [3:0]         channel_type,
	input  logic               direction,
	input  logic signed [31:0] low_limit,
	input  logic signed [31:0] high_limit,
	input  logic signed [31:0] sample,
	// result beats
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         overall_level,
	output logic               level_changed,
	output logic [15:0]        timer_reload,
	output logic [1:0]         channel_level,
	output logic               matched,
	output logic               table_full,
	// config writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam logic [1:0] REG_NORMAL_RELOAD = 2'd0;
	localparam logic [1:0] REG_LOW_RELOAD    = 2'd1;
	localparam logic [1:0] REG_HIGH_RELOAD   = 2'd2;

	localparam int IDX_W = taa_pkg::IDX_W;
	localparam int CNT_W = taa_pkg::CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	taa_pkg::level_t   sys_level_q;
	logic [15:0]       normal_reload_q;
	logic [15:0]       low_reload_q;
	logic [15:0]       high_reload_q;

	// per-item working registers
	logic              op_q;
	logic [3:0]        type_q;
	logic signed [31:0] sample_q;
	logic [IDX_W-1:0]  idx_q;
	taa_pkg::level_t   top_q;
	taa_pkg::level_t   chlvl_q;
	logic              matched_q;
	logic              full_q;

	// output register
	logic              out_valid_q;
	logic [1:0]        overall_q;
	logic              changed_q;
	logic [15:0]       reload_q;
	logic [1:0]        chlvl_out_q;
	logic              matched_out_q;
	logic              full_out_q;

	taa_pkg::tbl_wr_t  tbl_wr;
	logic [IDX_W-1:0]  rd_addr;
	taa_pkg::chan_t    rd_chan;
	taa_pkg::level_t   rd_level;
	taa_pkg::level_t   cls_level;
	taa_pkg::level_t   eff_level;
	logic              hit;
	logic              last;
	logic              accept;
	logic              table_has_room;
	logic              out_free;
	logic              load_out;
	logic [15:0]       reload_sel;

	assign accept         = in_valid && (state_q == ST_IDLE);
	assign in_stall       = state_q != ST_IDLE;
	assign table_has_room = count_q < CNT_W'(taa_pkg::CHANNELS);
	assign hit            = rd_chan.ctype == type_q;
	assign last           = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign eff_level      = hit ? cls_level : rd_level;
	assign out_free       = !out_valid_q || !out_stall;
	assign load_out       = (state_q == ST_FIN) && out_free;

	// next entry is fetched while the current one is graded
	assign rd_addr = (state_q == ST_WALK && !last) ? idx_q + IDX_W'(1) : '0;

	always_comb begin
		tbl_wr                = '0;
		tbl_wr.add_en         = accept && !op && table_has_room;
		tbl_wr.add_idx        = count_q[IDX_W-1:0];
		tbl_wr.add_chan.ctype = channel_type;
		tbl_wr.add_chan.dir   = direction;
		tbl_wr.add_chan.lo    = low_limit;
		tbl_wr.add_chan.hi    = high_limit;
		tbl_wr.lvl_en         = (state_q == ST_WALK) && hit;
		tbl_wr.lvl_idx        = idx_q;
		tbl_wr.lvl_val        = cls_level;
	end

	always_comb begin
		case (top_q)
			taa_pkg::LVL_HIGH: reload_sel = high_reload_q;
			taa_pkg::LVL_LOW:  reload_sel = low_reload_q;
			default:           reload_sel = normal_reload_q;
		endcase
	end

	taa_table u_table (
		.clk      (clk),
		.wr       (tbl_wr),
		.rd_addr  (rd_addr),
		.rd_chan  (rd_chan),
		.rd_level (rd_level)
	);

	taa_classify u_classify (
		.dir    (rd_chan.dir),
		.lo     (rd_chan.lo),
		.hi     (rd_chan.hi),
		.sample (sample_q),
		.level  (cls_level)
	);

	// config registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_reload_q <= 16'd1000;
			low_reload_q    <= 16'd500;
			high_reload_q   <= 16'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NORMAL_RELOAD: normal_reload_q <= cfg_data;
				REG_LOW_RELOAD:    low_reload_q    <= cfg_data;
				REG_HIGH_RELOAD:   high_reload_q   <= cfg_data;
				default:           ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sys_level_q <= taa_pkg::LVL_NORMAL;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q      <= op;
						type_q    <= channel_type;
						sample_q  <= sample;
						idx_q     <= '0;
						top_q     <= taa_pkg::LVL_NORMAL;
						chlvl_q   <= taa_pkg::LVL_NORMAL;
						matched_q <= 1'b0;
						full_q    <= !op && !table_has_room;
						if (!op) begin
							if (table_has_room) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= ST_FIN;
						end else if (count_q == '0) begin
							// empty table: overall level falls back to normal
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (hit) begin
						chlvl_q   <= cls_level;
						matched_q <= 1'b1;
					end
					if (eff_level > top_q) begin
						top_q <= eff_level;
					end
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						chlvl_out_q   <= op_q ? chlvl_q : taa_pkg::LVL_NORMAL;
						matched_out_q <= op_q && matched_q;
						full_out_q    <= !op_q && full_q;
						if (op_q && (top_q != sys_level_q)) begin
							sys_level_q <= top_q;
							overall_q   <= top_q;
							changed_q   <= 1'b1;
							reload_q    <= reload_sel;
						end else begin
							overall_q   <= sys_level_q;
							changed_q   <= 1'b0;
							reload_q    <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign overall_level = overall_q;
	assign level_changed = changed_q;
	assign timer_reload  = reload_q;
	assign channel_level = chlvl_out_q;
	assign matched       = matched_out_q;
	assign table_full    = full_out_q;

endmodule
